// ----- src/antspan_pkg.sv -----
// shared types and constants for the affine nearest texel span sampler
package antspan_pkg;

    // field widths
    localparam int COORD_W   = 16;
    localparam int MAT_W     = 32;
    localparam int SIZE_W    = 9;
    localparam int TEXEL_W   = 32;
    localparam int LOADIX_W  = 8;
    localparam int SPANCNT_W = 7;

    // fixed point: sums carry 17 fraction bits (pixel centre at half steps)
    localparam int FRAC_BITS = 17;
    localparam int PIX2_W    = COORD_W + 1;
    localparam int PROD_W    = MAT_W + PIX2_W;
    localparam int SUM_W     = 51;
    localparam int INT_W     = SUM_W - FRAC_BITS;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_INV_A      = 3'd0;
    localparam cfg_idx_t REG_INV_B      = 3'd1;
    localparam cfg_idx_t REG_INV_C      = 3'd2;
    localparam cfg_idx_t REG_INV_D      = 3'd3;
    localparam cfg_idx_t REG_INV_E      = 3'd4;
    localparam cfg_idx_t REG_INV_F      = 3'd5;
    localparam cfg_idx_t REG_TEX_WIDTH  = 3'd6;
    localparam cfg_idx_t REG_TEX_HEIGHT = 3'd7;

    // reset values
    localparam logic [MAT_W-1:0]  MAT_ONE   = 32'h0001_0000;
    localparam logic [MAT_W-1:0]  MAT_ZERO  = 32'h0000_0000;
    localparam logic [SIZE_W-1:0] SIZE_INIT = 9'd256;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SPAN = 1'b1;

endpackage

// ----- src/affine_nearest_texel_span.sv -----
// affine nearest texel span sampler with clamp to edge and a texel memory
// the first pixel of a span goes through the MUL and SUM states, the read register and the output register
// input: a span holds in_stall high through the MUL, SUM and RUN states; in RUN the single memory
//   read port gives one pixel per cycle unless out_stall holds it; loads are taken in IDLE
// reset: matrix and size registers return to identity and 256x256, control clears,
//   the texel memory is not cleared and reads of unwritten texels are undefined
module affine_nearest_texel_span
    import antspan_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_SPAN   = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_addr,
    input  logic [CFG_DAT_W-1:0]        cfg_wr_data,

    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic signed [COORD_W-1:0]   dev_x,
    input  logic signed [COORD_W-1:0]   dev_y,
    input  logic [SPANCNT_W-1:0]        span_count,
    input  logic [LOADIX_W-1:0]         load_col,
    input  logic [LOADIX_W-1:0]         load_row,
    input  logic [TEXEL_W-1:0]          load_texel,

    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [TEXEL_W-1:0]          pixel,
    output logic                        last
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CNT_W  = $clog2(MAX_SPAN + 1);

    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_WIDTH);
    localparam logic [COL_W-1:0]  COL_MAX    = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX    = ROW_W'(MAX_HEIGHT - 1);
    localparam logic [CNT_W-1:0]  SPAN_MAX   = CNT_W'(MAX_SPAN);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // takes loads and spans
    localparam logic [1:0] ST_MUL  = 2'd1;  // matrix products of the first pixel centre
    localparam logic [1:0] ST_SUM  = 2'd2;  // add products and translation
    localparam logic [1:0] ST_RUN  = 2'd3;  // one texel read per cycle unless the output stalls

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [MAT_W-1:0]  inv_a_reg, inv_b_reg, inv_c_reg, inv_d_reg, inv_e_reg, inv_f_reg;
    logic [SIZE_W-1:0] tex_width_reg, tex_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_a_reg      <= MAT_ONE;
            inv_b_reg      <= MAT_ZERO;
            inv_c_reg      <= MAT_ZERO;
            inv_d_reg      <= MAT_ZERO;
            inv_e_reg      <= MAT_ONE;
            inv_f_reg      <= MAT_ZERO;
            tex_width_reg  <= SIZE_INIT;
            tex_height_reg <= SIZE_INIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_INV_A:      inv_a_reg      <= cfg_wr_data;
                REG_INV_B:      inv_b_reg      <= cfg_wr_data;
                REG_INV_C:      inv_c_reg      <= cfg_wr_data;
                REG_INV_D:      inv_d_reg      <= cfg_wr_data;
                REG_INV_E:      inv_e_reg      <= cfg_wr_data;
                REG_INV_F:      inv_f_reg      <= cfg_wr_data;
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_wr_data[SIZE_W-1:0];
                REG_TEX_HEIGHT: tex_height_reg <= cfg_wr_data[SIZE_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control and datapath registers
    // ------------------------------------------------------------------
    logic [1:0]                state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      rd_vld_reg, rd_vld_next;    // mem_q_reg holds an unsent texel
    logic                      out_vld_reg, out_vld_next;

    logic signed [PIX2_W-1:0]  px2_reg, px2_next;          // 2*dev_x + 1
    logic signed [PIX2_W-1:0]  py2_reg, py2_next;          // 2*dev_y + 1
    logic [COL_W-1:0]          w_lim_reg, w_lim_next;      // clamped width - 1
    logic [ROW_W-1:0]          h_lim_reg, h_lim_next;      // clamped height - 1
    logic signed [PROD_W-1:0]  pa_reg, pb_reg, pd_reg, pe_reg;
    logic signed [PROD_W-1:0]  pa_next, pb_next, pd_next, pe_next;
    logic signed [SUM_W-1:0]   su_reg, su_next;            // u in 2^-17 units
    logic signed [SUM_W-1:0]   sv_reg, sv_next;            // v in 2^-17 units
    logic                      rd_last_reg, rd_last_next;
    logic [TEXEL_W-1:0]        pixel_reg, pixel_next;
    logic                      last_reg, last_next;

    logic [TEXEL_W-1:0]        mem_q_reg;

    logic                      in_acc;
    logic                      out_ready;
    logic                      mv;          // texel moves from read stage to output register
    logic                      rd_en;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic [INT_W-1:0]          q_u, q_v;    // floor of u and v
    logic [COL_W-1:0]          col;
    logic [ROW_W-1:0]          row;
    logic [CNT_W-1:0]          span_cnt;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;

    assign out_ready = !out_vld_reg || !out_stall;
    assign mv        = rd_vld_reg && out_ready;
    // a new read may go out when the read stage is empty or empties this cycle
    assign rd_en     = (state_reg == ST_RUN) && (!rd_vld_reg || mv);

    // load items write straight into the memory; out-of-range addresses drop
    assign wr_en   = in_acc && (cmd == CMD_LOAD)
                     && (32'(load_col) < MAX_WIDTH) && (32'(load_row) < MAX_HEIGHT);
    assign wr_addr = ADDR_W'(ADDR_W'(load_row) * ROW_STRIDE) + ADDR_W'(load_col);

    // span length saturates at the maximum
    assign span_cnt = (32'(span_count) > MAX_SPAN) ? SPAN_MAX : CNT_W'(span_count);

    // floor by arithmetic shift, then clamp to the bitmap
    assign q_u = su_reg[SUM_W-1:FRAC_BITS];
    assign q_v = sv_reg[SUM_W-1:FRAC_BITS];

    always_comb
    begin
        if (q_u[INT_W-1])
            col = '0;
        else if (q_u > INT_W'(w_lim_reg))
            col = w_lim_reg;
        else
            col = q_u[COL_W-1:0];

        if (q_v[INT_W-1])
            row = '0;
        else if (q_v > INT_W'(h_lim_reg))
            row = h_lim_reg;
        else
            row = q_v[ROW_W-1:0];
    end

    assign rd_addr = ADDR_W'(ADDR_W'(row) * ROW_STRIDE) + ADDR_W'(col);

    // size limits are latched with each taken input item: zero reads as one, large values saturate
    always_comb
    begin
        if (tex_width_reg == '0)
            w_lim_next = '0;
        else if (32'(tex_width_reg) > MAX_WIDTH)
            w_lim_next = COL_MAX;
        else
            w_lim_next = COL_W'(tex_width_reg - SIZE_W'(1));

        if (tex_height_reg == '0)
            h_lim_next = '0;
        else if (32'(tex_height_reg) > MAX_HEIGHT)
            h_lim_next = ROW_MAX;
        else
            h_lim_next = ROW_W'(tex_height_reg - SIZE_W'(1));
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        px2_next     = {dev_x, 1'b1};
        py2_next     = {dev_y, 1'b1};
        pa_next      = $signed(inv_a_reg) * px2_reg;
        pb_next      = $signed(inv_b_reg) * py2_reg;
        pd_next      = $signed(inv_d_reg) * px2_reg;
        pe_next      = $signed(inv_e_reg) * py2_reg;
        su_next      = su_reg;
        sv_next      = sv_reg;
        rd_last_next = rd_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // a span of length zero gives nothing and stays here
                if (in_acc && (cmd == CMD_SPAN) && (span_cnt != '0))
                begin
                    state_next = ST_MUL;
                    cnt_next   = span_cnt;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                su_next    = SUM_W'(pa_reg) + SUM_W'(pb_reg)
                             + SUM_W'($signed({inv_c_reg, 1'b0}));
                sv_next    = SUM_W'(pd_reg) + SUM_W'(pe_reg)
                             + SUM_W'($signed({inv_f_reg, 1'b0}));
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (rd_en)
                begin
                    // next pixel centre is one device step, two half steps, to the right
                    su_next      = su_reg + SUM_W'($signed({inv_a_reg, 1'b0}));
                    sv_next      = sv_reg + SUM_W'($signed({inv_d_reg, 1'b0}));
                    rd_last_next = (cnt_reg == CNT_W'(1));
                    cnt_next     = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read stage and output register
    always_comb
    begin
        rd_vld_next  = rd_vld_reg;
        out_vld_next = out_vld_reg;
        pixel_next   = pixel_reg;
        last_next    = last_reg;

        if (rd_en)
            rd_vld_next = 1'b1;
        else if (mv)
            rd_vld_next = 1'b0;

        if (mv)
        begin
            out_vld_next = 1'b1;
            pixel_next   = mem_q_reg;
            last_next    = rd_last_reg;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px2_reg   <= px2_next;
            py2_reg   <= py2_next;
            w_lim_reg <= w_lim_next;
            h_lim_reg <= h_lim_next;
        end
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        pd_reg      <= pd_next;
        pe_reg      <= pe_next;
        su_reg      <= su_next;
        sv_reg      <= sv_next;
        rd_last_reg <= rd_last_next;
        pixel_reg   <= pixel_next;
        last_reg    <= last_next;
    end

    // ------------------------------------------------------------------
    // texel memory: one write port for loads, one registered read port
    // ------------------------------------------------------------------
    logic [TEXEL_W-1:0] texel_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            texel_mem[wr_addr] <= load_texel;
        if (rd_en)
            mem_q_reg <= texel_mem[rd_addr];
    end

    assign out_valid = out_vld_reg;
    assign pixel     = pixel_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a texel waiting in the read stage is not overwritten by a new read
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg && !mv |-> !rd_en)
        else $error("read issued over a waiting texel");

    // the read data register holds while its texel waits
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg && !mv |=> $stable(mem_q_reg))
        else $error("waiting texel changed");

    // the pixel loop never runs with nothing left to read
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> cnt_reg != '0)
        else $error("pixel loop running with zero count");

    // an empty span leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && cmd == CMD_SPAN && span_count == '0 |=> state_reg == ST_IDLE)
        else $error("empty span started the sequencer");

endmodule
